[hdl/sdr_pkg.sv]
// shared widths, constants and types of the sub-pixel disparity refine unit
// no dependencies; imported by every module of the block
package sdr_pkg;

  // fixed point format and disparity range
  localparam int FRAC_BITS = 6;
  localparam int MAX_DISP  = 128;

  // field widths
  localparam int IN_W   = 8;
  localparam int REF_W  = 14;
  localparam int OFS_W  = 13;
  localparam int COST_W = 16;

  // saturation bounds of the result fields
  localparam int REF_MAX  = (1 << REF_W) - 1;
  localparam int REF_MIN  = 0;
  localparam int OFS_MAX  = (1 << (OFS_W - 1)) - 1;
  localparam int OFS_MIN  = -(1 << (OFS_W - 1));
  localparam int COST_MAX = (1 << (COST_W - 1)) - 1;
  localparam int COST_MIN = -(1 << (COST_W - 1));

  // parabola term widths: a2 = -2a, b2 = -2b for the costs at x = 0, 1, 2
  localparam int CS_W  = 12;
  localparam int A2_W  = 11;
  localparam int AA_W  = A2_W - 1;
  localparam int B2_W  = 12;
  localparam int DM_W  = IN_W + 2;
  localparam int PR_W  = 21;
  localparam int PC_W  = 20;
  localparam int BSQ_W = 24;
  localparam int NR_W  = 23;
  localparam int NO_W  = 13;
  localparam int NC_W  = 24;

  // divider: magnitude of scaled numerator, divisor and quotient widths
  localparam int MAG_W     = 22 + FRAC_BITS;
  localparam int DEN_W     = 12;
  localparam int DIV_QW    = 16;
  localparam int DIV_STEPS = 4;
  localparam int DIV_STG   = DIV_QW / DIV_STEPS;
  localparam int SAT_W     = DIV_QW + 2;

  // pipeline: three setup stages, divider stages, output register
  localparam int PRE_STG = 3;
  localparam int NSTG    = PRE_STG + DIV_STG + 1;

  typedef struct packed {
    logic [MAG_W-1:0] mag;
    logic [DEN_W-1:0] den;
    logic             neg;
  } div_in_t;

  typedef struct packed {
    logic [DIV_QW-1:0] quo;
    logic              ovf;
    logic              neg;
  } div_out_t;

  typedef struct packed {
    logic [IN_W-1:0] disp;
    logic [IN_W-1:0] cost_c;
    logic            fit;
  } side_t;

endpackage

[hdl/sdr_div.sv]
// pipelined restoring divider with round-half-up numerator already applied
// depends on sdr_pkg; DIV_STEPS quotient bits per stage, DIV_STG stages
module sdr_div import sdr_pkg::*; (
  input  logic               clk_i,
  input  logic [DIV_STG-1:0] en_i,
  input  div_in_t            req_i,
  output div_out_t           res_o
);

  logic [DEN_W-1:0]  rem_in  [DIV_STG];
  logic [DEN_W-1:0]  rem_d   [DIV_STG];
  logic [DEN_W-1:0]  rem_q   [DIV_STG];
  logic [DIV_QW-1:0] low_in  [DIV_STG];
  logic [DIV_QW-1:0] low_d   [DIV_STG];
  logic [DIV_QW-1:0] low_q   [DIV_STG];
  logic [DIV_QW-1:0] quo_in  [DIV_STG];
  logic [DIV_QW-1:0] quo_d   [DIV_STG];
  logic [DIV_QW-1:0] quo_q   [DIV_STG];
  logic [DEN_W-1:0]  den_in  [DIV_STG];
  logic [DEN_W-1:0]  den_q   [DIV_STG];
  logic              ovf_in  [DIV_STG];
  logic              ovf_q   [DIV_STG];
  logic              neg_in  [DIV_STG];
  logic              neg_q   [DIV_STG];
  logic              ovf_first;

  // quotient does not fit in DIV_QW bits (also catches a zero divisor)
  assign ovf_first = (MAG_W + DEN_W)'(req_i.mag) >=
                     ((MAG_W + DEN_W)'(req_i.den) << DIV_QW);

  for (genvar k = 0; k < DIV_STG; k++) begin : g_stg
    // stage inputs
    if (k == 0) begin : g_first
      assign rem_in[k] = DEN_W'(req_i.mag >> DIV_QW);
      assign low_in[k] = req_i.mag[DIV_QW-1:0];
      assign quo_in[k] = '0;
      assign den_in[k] = req_i.den;
      assign ovf_in[k] = ovf_first;
      assign neg_in[k] = req_i.neg;
    end else begin : g_next
      assign rem_in[k] = rem_q[k-1];
      assign low_in[k] = low_q[k-1];
      assign quo_in[k] = quo_q[k-1];
      assign den_in[k] = den_q[k-1];
      assign ovf_in[k] = ovf_q[k-1];
      assign neg_in[k] = neg_q[k-1];
    end

    // shift-subtract steps of this stage
    always_comb begin
      logic [DEN_W:0]    trial;
      logic [DEN_W-1:0]  rem;
      logic [DIV_QW-1:0] low;
      logic [DIV_QW-1:0] quo;
      rem = rem_in[k];
      low = low_in[k];
      quo = quo_in[k];
      for (int j = 0; j < DIV_STEPS; j++) begin
        trial = {rem, low[DIV_QW-1]};
        low   = {low[DIV_QW-2:0], 1'b0};
        if (trial >= {1'b0, den_in[k]}) begin
          rem = DEN_W'(trial - {1'b0, den_in[k]});
          quo = {quo[DIV_QW-2:0], 1'b1};
        end else begin
          rem = trial[DEN_W-1:0];
          quo = {quo[DIV_QW-2:0], 1'b0};
        end
      end
      rem_d[k] = rem;
      low_d[k] = low;
      quo_d[k] = quo;
    end

    // stage register
    always_ff @(posedge clk_i) begin
      if (en_i[k]) begin
        rem_q[k] <= rem_d[k];
        low_q[k] <= low_d[k];
        quo_q[k] <= quo_d[k];
        den_q[k] <= den_in[k];
        ovf_q[k] <= ovf_in[k];
        neg_q[k] <= neg_in[k];
      end
    end
  end

  assign res_o.quo = quo_q[DIV_STG-1];
  assign res_o.ovf = ovf_q[DIV_STG-1];
  assign res_o.neg = neg_q[DIV_STG-1];

endmodule

[hdl/subpixel_disparity_refine_unit.sv]
// 8 register stages; a result is offered from the output register, the last of them
// throughput: one request per cycle while the output is not stalled; the four-stage
// divider (4 quotient bits per stage, three dividers in parallel) sets the pipeline depth
// an output stall holds the full stages in place, empty stages still fill
// reset clears the stage valid bits only; data registers are not reset
// depends on sdr_pkg and sdr_div
module subpixel_disparity_refine_unit import sdr_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [IN_W-1:0]          cost_prev_i,
  input  logic [IN_W-1:0]          cost_center_i,
  input  logic [IN_W-1:0]          cost_next_i,
  input  logic [IN_W-1:0]          disparity_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [REF_W-1:0]         refined_disparity_o,
  output logic signed [OFS_W-1:0]  subpixel_offset_o,
  output logic signed [COST_W-1:0] min_cost_o,
  output logic                     valid_fit_o
);

  // clamp a sign/magnitude quotient to a field range
  function automatic logic signed [SAT_W-1:0] sat_fix(
    input logic                    neg,
    input logic                    ovf,
    input logic [DIV_QW-1:0]       quo,
    input logic signed [SAT_W-1:0] lo,
    input logic signed [SAT_W-1:0] hi
  );
    logic signed [SAT_W-1:0] val;
    logic signed [SAT_W-1:0] res;
    val = neg ? -$signed(SAT_W'(quo)) : $signed(SAT_W'(quo));
    if (ovf) begin
      res = neg ? lo : hi;
    end else if (val < lo) begin
      res = lo;
    end else if (val > hi) begin
      res = hi;
    end else begin
      res = val;
    end
    return res;
  endfunction

  logic [NSTG-1:0] vld_d, vld_q;
  logic [NSTG-1:0] adv;
  side_t           side_d;
  side_t           side_q [NSTG-1];

  // stage enables: a stage loads when empty or when its successor moves
  always_comb begin
    adv[NSTG-1] = !vld_q[NSTG-1] || out_ready_i;
    for (int k = NSTG - 2; k >= 0; k--) begin
      adv[k] = !vld_q[k] || adv[k+1];
    end
  end

  always_comb begin
    vld_d[0] = adv[0] ? in_valid_i : vld_q[0];
    for (int k = 1; k < NSTG; k++) begin
      vld_d[k] = adv[k] ? vld_q[k-1] : vld_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign in_ready_o  = adv[0];
  assign out_valid_o = vld_q[NSTG-1];

  // side data travels with each request
  for (genvar k = 0; k < NSTG - 1; k++) begin : g_side
    if (k == 0) begin : g_first
      always_ff @(posedge clk_i) begin
        if (adv[k]) begin
          side_q[k] <= side_d;
        end
      end
    end else begin : g_next
      always_ff @(posedge clk_i) begin
        if (adv[k]) begin
          side_q[k] <= side_q[k-1];
        end
      end
    end
  end

  // stage 1: curvature and slope terms, fit decision
  logic signed [CS_W-1:0] c0s, c1s, c2s;
  logic signed [A2_W-1:0] a2_d, a2_s1_q;
  logic signed [B2_W-1:0] b2_d, b2_s1_q;
  logic [IN_W-1:0]        c0_s1_q;

  assign c0s  = $signed({{(CS_W - IN_W){1'b0}}, cost_prev_i});
  assign c1s  = $signed({{(CS_W - IN_W){1'b0}}, cost_center_i});
  assign c2s  = $signed({{(CS_W - IN_W){1'b0}}, cost_next_i});
  assign a2_d = A2_W'(2 * c1s - c0s - c2s);
  assign b2_d = B2_W'(3 * c0s - 4 * c1s + c2s);

  assign side_d.disp   = disparity_i;
  assign side_d.cost_c = cost_center_i;
  assign side_d.fit    = (a2_d != '0) && (disparity_i != '0) &&
                         ({1'b0, disparity_i} < (IN_W + 1)'(MAX_DISP));

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      a2_s1_q <= a2_d;
      b2_s1_q <= b2_d;
      c0_s1_q <= cost_prev_i;
    end
  end

  // stage 2: numerators of the three quotients
  logic signed [DM_W-1:0]  dm1;
  logic signed [PR_W-1:0]  prod_r;
  logic signed [PC_W-1:0]  prod_c;
  logic signed [BSQ_W-1:0] b2_sq;
  logic signed [NR_W-1:0]  num_r_d, num_r_q;
  logic signed [NO_W-1:0]  num_o_d, num_o_q;
  logic signed [NC_W-1:0]  num_c_d, num_c_q;
  logic signed [A2_W-1:0]  a2_s2_q;

  assign dm1     = $signed({2'b00, side_q[0].disp}) - DM_W'(1);
  assign prod_r  = PR_W'(dm1) * PR_W'(a2_s1_q);
  assign prod_c  = PC_W'($signed({1'b0, c0_s1_q})) * PC_W'(a2_s1_q);
  assign b2_sq   = BSQ_W'(b2_s1_q) * BSQ_W'(b2_s1_q);
  assign num_r_d = (NR_W'(prod_r) <<< 1) - NR_W'(b2_s1_q);
  assign num_o_d = -(NO_W'(a2_s1_q) <<< 1) - NO_W'(b2_s1_q);
  assign num_c_d = (NC_W'(prod_c) <<< 3) + NC_W'(b2_sq);

  always_ff @(posedge clk_i) begin
    if (adv[1]) begin
      num_r_q <= num_r_d;
      num_o_q <= num_o_d;
      num_c_q <= num_c_d;
      a2_s2_q <= a2_s1_q;
    end
  end

  // stage 3: magnitudes, scaling and rounding bias, divisors
  logic [AA_W-1:0] abs_a2;
  logic [NR_W-1:0] abs_nr;
  logic [NO_W-1:0] abs_no;
  logic [NC_W-1:0] abs_nc;
  div_in_t         req_r_d, req_r_q;
  div_in_t         req_o_d, req_o_q;
  div_in_t         req_c_d, req_c_q;

  always_comb begin
    abs_a2 = AA_W'(a2_s2_q[A2_W-1] ? -a2_s2_q : a2_s2_q);
    abs_nr = num_r_q[NR_W-1] ? NR_W'(-num_r_q) : NR_W'(num_r_q);
    abs_no = num_o_q[NO_W-1] ? NO_W'(-num_o_q) : NO_W'(num_o_q);
    abs_nc = num_c_q[NC_W-1] ? NC_W'(-num_c_q) : NC_W'(num_c_q);

    req_r_d.mag = (MAG_W'(abs_nr) << FRAC_BITS) + MAG_W'(abs_a2);
    req_r_d.den = DEN_W'(abs_a2) << 1;
    req_r_d.neg = num_r_q[NR_W-1] ^ a2_s2_q[A2_W-1];

    req_o_d.mag = (MAG_W'(abs_no) << FRAC_BITS) + MAG_W'(abs_a2);
    req_o_d.den = DEN_W'(abs_a2) << 1;
    req_o_d.neg = num_o_q[NO_W-1] ^ a2_s2_q[A2_W-1];

    req_c_d.mag = (MAG_W'(abs_nc) << FRAC_BITS) + (MAG_W'(abs_a2) << 2);
    req_c_d.den = DEN_W'(abs_a2) << 3;
    req_c_d.neg = num_c_q[NC_W-1] ^ a2_s2_q[A2_W-1];
  end

  always_ff @(posedge clk_i) begin
    if (adv[2]) begin
      req_r_q <= req_r_d;
      req_o_q <= req_o_d;
      req_c_q <= req_c_d;
    end
  end

  // dividers
  div_out_t res_r, res_o, res_c;

  sdr_div u_div_ref (
    .clk_i (clk_i),
    .en_i  (adv[PRE_STG +: DIV_STG]),
    .req_i (req_r_q),
    .res_o (res_r)
  );

  sdr_div u_div_ofs (
    .clk_i (clk_i),
    .en_i  (adv[PRE_STG +: DIV_STG]),
    .req_i (req_o_q),
    .res_o (res_o)
  );

  sdr_div u_div_cost (
    .clk_i (clk_i),
    .en_i  (adv[PRE_STG +: DIV_STG]),
    .req_i (req_c_q),
    .res_o (res_c)
  );

  // output stage: saturate the fit results, or pass the integer disparity and center cost through with zero offset
  side_t                   side_out;
  logic signed [SAT_W-1:0] sat_ref, sat_ofs, sat_cost;
  logic [31:0]             fb_ref, fb_cost;
  logic [REF_W-1:0]        ref_fb, ref_d, ref_q;
  logic signed [COST_W-1:0] cost_fb, cost_d, cost_q;
  logic signed [OFS_W-1:0] ofs_d, ofs_q;
  logic                    fit_q;

  assign side_out = side_q[NSTG-2];

  always_comb begin
    sat_ref  = sat_fix(res_r.neg, res_r.ovf, res_r.quo,
                       SAT_W'(REF_MIN), SAT_W'(REF_MAX));
    sat_ofs  = sat_fix(res_o.neg, res_o.ovf, res_o.quo,
                       SAT_W'(OFS_MIN), SAT_W'(OFS_MAX));
    sat_cost = sat_fix(res_c.neg, res_c.ovf, res_c.quo,
                       SAT_W'(COST_MIN), SAT_W'(COST_MAX));

    fb_ref  = 32'(side_out.disp) << FRAC_BITS;
    fb_cost = 32'(side_out.cost_c) << FRAC_BITS;
    ref_fb  = (fb_ref > 32'(REF_MAX)) ? REF_W'(REF_MAX) : REF_W'(fb_ref);
    cost_fb = (fb_cost > 32'(COST_MAX)) ? COST_W'(COST_MAX) : COST_W'(fb_cost);

    if (side_out.fit) begin
      ref_d  = REF_W'(sat_ref);
      ofs_d  = OFS_W'(sat_ofs);
      cost_d = COST_W'(sat_cost);
    end else begin
      ref_d  = ref_fb;
      ofs_d  = '0;
      cost_d = cost_fb;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[NSTG-1]) begin
      ref_q  <= ref_d;
      ofs_q  <= ofs_d;
      cost_q <= cost_d;
      fit_q  <= side_out.fit;
    end
  end

  assign refined_disparity_o = ref_q;
  assign subpixel_offset_o   = ofs_q;
  assign min_cost_o          = cost_q;
  assign valid_fit_o         = fit_q;

endmodule

[hdl/sdr_checker.sv]
// port-level checks of the sub-pixel disparity refine unit, bound to the top
// depends on sdr_pkg and subpixel_disparity_refine_unit
module sdr_checker import sdr_pkg::*; (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_valid_i,
  input logic                     in_ready_o,
  input logic                     out_valid_o,
  input logic                     out_ready_i,
  input logic signed [OFS_W-1:0]  subpixel_offset_o,
  input logic signed [COST_W-1:0] min_cost_o,
  input logic                     valid_fit_o
);

  localparam int CNT_W = $clog2(NSTG + 1);

  logic [CNT_W-1:0] cnt_d, cnt_q;
  logic             in_acc, out_acc;

  // requests in flight
  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = out_valid_o && out_ready_i;
  assign cnt_d   = cnt_q + CNT_W'(in_acc) - CNT_W'(out_acc);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result withdrawn while stalled");

  // no result without an accepted request behind it
  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> cnt_q != '0)
    else $error("result without a pending request");

  // the pipeline never holds more requests than it has stages
  a_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(NSTG))
    else $error("more requests in flight than pipeline stages");

  // pass-through results carry zero offset and a non-negative cost
  a_passthru: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !valid_fit_o |-> subpixel_offset_o == '0 && !min_cost_o[COST_W-1])
    else $error("pass-through result with offset or negative cost");

endmodule

bind subpixel_disparity_refine_unit sdr_checker u_sdr_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_valid_i),
  .in_ready_o        (in_ready_o),
  .out_valid_o       (out_valid_o),
  .out_ready_i       (out_ready_i),
  .subpixel_offset_o (subpixel_offset_o),
  .min_cost_o        (min_cost_o),
  .valid_fit_o       (valid_fit_o)
);

[dv/tb_subpixel_disparity_refine_unit.sv]
// testbench of the sub-pixel disparity refine unit: directed and random requests,
// a parabola-fit predictor and an in-order scoreboard of expected fit results
// depends on sdr_pkg and the subpixel_disparity_refine_unit rtl
`timescale 1ns / 1ps

module tb_subpixel_disparity_refine_unit;
  import sdr_pkg::*;

  localparam int N_RANDOM    = 450;
  localparam int IDLE_LIMIT  = 2000;
  localparam int PIPE_CYCLES = 8;

  // one expected result of the block
  typedef struct {
    logic [REF_W-1:0]         refd;
    logic signed [OFS_W-1:0]  ofs;
    logic signed [COST_W-1:0] cost;
    logic                     fit;
  } fit_result_t;

  // parabola-fit predictor and in-order store of expected results
  class fit_scoreboard;
    fit_result_t fit_q[$];
    int errors;
    int n_checked;
    int n_fit;

    function new();
      errors    = 0;
      n_checked = 0;
      n_fit     = 0;
    endfunction

    // rounded quotient, ties away from zero
    function automatic longint div_round(longint num, longint den);
      longint un;
      longint ud;
      longint q;
      bit     neg;
      un  = (num < 0) ? -num : num;
      ud  = (den < 0) ? -den : den;
      neg = (num < 0) != (den < 0);
      if (ud == 0) return 0;
      q = (un + ud / 2) / ud;
      return neg ? -q : q;
    endfunction

    function automatic longint clip(longint v, longint lo, longint hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
    endfunction

    // vertex of the parabola through the three costs
    function automatic fit_result_t fit_parabola(logic [IN_W-1:0] c0, logic [IN_W-1:0] c1,
                                                 logic [IN_W-1:0] c2, logic [IN_W-1:0] d);
      fit_result_t r;
      longint p, c, n, dd, a2, b2, sc;
      longint refd, ofs, cost;
      p  = c0;
      c  = c1;
      n  = c2;
      dd = d;
      sc = longint'(1) << FRAC_BITS;
      a2 = -p + 2 * c - n;
      b2 = 3 * p - 4 * c + n;
      if (a2 == 0 || dd == 0 || dd >= MAX_DISP) begin
        refd  = dd * sc;
        ofs   = 0;
        cost  = c * sc;
        r.fit = 1'b0;
      end else begin
        refd  = div_round(((dd - 1) * 2 * a2 - b2) * sc, 2 * a2);
        ofs   = div_round((-2 * a2 - b2) * sc, 2 * a2);
        cost  = div_round((p * 8 * a2 + b2 * b2) * sc, 8 * a2);
        r.fit = 1'b1;
      end
      refd   = clip(refd, REF_MIN, REF_MAX);
      ofs    = clip(ofs, OFS_MIN, OFS_MAX);
      cost   = clip(cost, COST_MIN, COST_MAX);
      r.refd = refd[REF_W-1:0];
      r.ofs  = ofs[OFS_W-1:0];
      r.cost = cost[COST_W-1:0];
      return r;
    endfunction

    function void note_request(logic [IN_W-1:0] c0, logic [IN_W-1:0] c1,
                               logic [IN_W-1:0] c2, logic [IN_W-1:0] d);
      fit_q.push_back(fit_parabola(c0, c1, c2, d));
    endfunction

    function void check_result(logic [REF_W-1:0] refd, logic signed [OFS_W-1:0] ofs,
                               logic signed [COST_W-1:0] cost, logic fit);
      fit_result_t e;
      if (fit_q.size() == 0) begin
        $display("%0t: unexpected result refined=%0d offset=%0d cost=%0d fit=%0b",
                 $time, refd, ofs, cost, fit);
        errors++;
        return;
      end
      e = fit_q.pop_front();
      n_checked++;
      if (e.fit) n_fit++;
      if (refd !== e.refd) begin
        $display("%0t: refined_disparity expected %0d actual %0d", $time, e.refd, refd);
        errors++;
      end
      if (ofs !== e.ofs) begin
        $display("%0t: subpixel_offset expected %0d actual %0d", $time, e.ofs, ofs);
        errors++;
      end
      if (cost !== e.cost) begin
        $display("%0t: min_cost expected %0d actual %0d", $time, e.cost, cost);
        errors++;
      end
      if (fit !== e.fit) begin
        $display("%0t: valid_fit expected %0b actual %0b", $time, e.fit, fit);
        errors++;
      end
    endfunction

    function int pending();
      return fit_q.size();
    endfunction
  endclass

  logic                     clk_i         = 1'b0;
  logic                     rst_ni        = 1'b0;
  logic                     in_valid_i    = 1'b0;
  logic                     in_ready_o;
  logic [IN_W-1:0]          cost_prev_i   = '0;
  logic [IN_W-1:0]          cost_center_i = '0;
  logic [IN_W-1:0]          cost_next_i   = '0;
  logic [IN_W-1:0]          disparity_i   = '0;
  logic                     out_valid_o;
  logic                     out_ready_i   = 1'b0;
  logic [REF_W-1:0]         refined_disparity_o;
  logic signed [OFS_W-1:0]  subpixel_offset_o;
  logic signed [COST_W-1:0] min_cost_o;
  logic                     valid_fit_o;

  fit_scoreboard sb = new();
  int send_calm  = 0;
  int stall_calm = 0;
  int n_sent     = 0;

  subpixel_disparity_refine_unit u_top (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .cost_prev_i        (cost_prev_i),
    .cost_center_i      (cost_center_i),
    .cost_next_i        (cost_next_i),
    .disparity_i        (disparity_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .refined_disparity_o(refined_disparity_o),
    .subpixel_offset_o  (subpixel_offset_o),
    .min_cost_o         (min_cost_o),
    .valid_fit_o        (valid_fit_o)
  );

  always #5 clk_i = ~clk_i;

  // gap length: mostly short, a few long, with runs of no gap at all
  function automatic int pick_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      calm = $urandom_range(20, 60);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // present one request and hold it until accepted
  task automatic send_request(input logic [IN_W-1:0] c0, input logic [IN_W-1:0] c1,
                              input logic [IN_W-1:0] c2, input logic [IN_W-1:0] d);
    int gap;
    gap = pick_gap(send_calm);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    cost_prev_i   <= c0;
    cost_center_i <= c1;
    cost_next_i   <= c2;
    disparity_i   <= d;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_request(c0, c1, c2, d);
    n_sent++;
  endtask

  // hold off new requests until every expected result is back
  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.pending() > 0);
  endtask

  // random request, mostly convex fits with the center near the minimum
  task automatic send_random_request();
    int kind;
    int p, c, n, d;
    kind = $urandom_range(0, 99);
    d    = $urandom_range(1, MAX_DISP - 1);
    c    = $urandom_range(0, 255);
    p    = $urandom_range(0, 255);
    n    = $urandom_range(0, 255);
    if (kind < 55) begin
      p = $urandom_range(c, 255);
      n = $urandom_range(c, 255);
    end else if (kind < 65) begin
      // nearly flat curvature drives the vertex far out
      c = (p + n + int'($urandom_range(0, 4)) - 2) / 2;
      if (c < 0) c = 0;
      if (c > 255) c = 255;
    end else if (kind < 80) begin
      d = $urandom_range(0, 255);
    end else if (kind < 90) begin
      case ($urandom_range(0, 5))
        0: d = 0;
        1: d = 1;
        2: d = MAX_DISP - 1;
        3: d = MAX_DISP;
        4: d = 255;
        default: d = $urandom_range(MAX_DISP, 255);
      endcase
    end else begin
      // exactly flat: center on the line through the outer costs
      n = (p % 2 == n % 2) ? n : n ^ 1;
      c = (p + n) / 2;
    end
    send_request(p[IN_W-1:0], c[IN_W-1:0], n[IN_W-1:0], d[IN_W-1:0]);
  endtask

  // result side: random stalls of the receiver
  initial begin
    int gap;
    @(posedge rst_ni);
    forever begin
      out_ready_i <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      gap = pick_gap(stall_calm);
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  end

  // compare every accepted result
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      sb.check_result(refined_disparity_o, subpixel_offset_o, min_cost_o, valid_fit_o);
    end
  end

  // watchdog on cycles with no handshake on either side
  initial begin
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle = 0;
      else idle++;
    end
    $display("%0t: no handshake for %0d cycles, %0d results outstanding",
             $time, IDLE_LIMIT, sb.pending());
    $display("tb_subpixel_disparity_refine_unit failed");
    $finish;
  end

  // main sequence
  initial begin
    int n_directed;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: field extremes, flat curvature, disparity bounds, concave, saturation
    send_request(8'd0,   8'd0,   8'd0,   8'd0);
    send_request(8'd255, 8'd0,   8'd255, 8'd64);
    send_request(8'd0,   8'd255, 8'd0,   8'd64);
    send_request(8'd255, 8'd255, 8'd255, 8'd1);
    send_request(8'd10,  8'd5,   8'd20,  8'd1);
    send_request(8'd10,  8'd5,   8'd20,  IN_W'(MAX_DISP - 1));
    send_request(8'd10,  8'd5,   8'd20,  IN_W'(MAX_DISP));
    send_request(8'd200, 8'd10,  8'd30,  8'd255);
    send_request(8'd200, 8'd10,  8'd30,  8'd0);
    send_request(8'd0,   8'd128, 8'd255, 8'd64);
    send_request(8'd255, 8'd127, 8'd0,   8'd1);
    send_request(8'd255, 8'd128, 8'd0,   8'd1);
    send_request(8'd255, 8'd127, 8'd0,   IN_W'(MAX_DISP - 1));
    send_request(8'd0,   8'd0,   8'd255, 8'd1);
    send_request(8'd255, 8'd0,   8'd0,   IN_W'(MAX_DISP - 1));
    send_request(8'd20,  8'd10,  8'd20,  8'd50);
    send_request(8'd21,  8'd10,  8'd20,  8'd50);
    send_request(8'd0,   8'd1,   8'd3,   8'd100);
    send_request(8'd3,   8'd1,   8'd0,   8'd100);
    send_request(8'd170, 8'd85,  8'd0,   8'd33);
    send_request(8'd255, 8'd255, 8'd0,   8'd127);
    n_directed = n_sent;
    drain_results();

    // random part, with one full drain in the middle
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == N_RANDOM / 2) drain_results();
      send_random_request();
    end
    in_valid_i <= 1'b0;

    // wait for the tail of the pipeline
    while (sb.pending() > 0) @(posedge clk_i);
    repeat (4 * PIPE_CYCLES) @(posedge clk_i);

    $display("run covered %0d directed and %0d random requests, %0d results checked",
             n_directed, n_sent - n_directed, sb.n_checked);
    $display("%0d results used the parabola fit, %0d fell back to the integer disparity",
             sb.n_fit, sb.n_checked - sb.n_fit);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb_subpixel_disparity_refine_unit passed");
    end else begin
      $display("tb_subpixel_disparity_refine_unit failed");
    end
    $finish;
  end

endmodule
